[sv/gps_pkg.sv]
// Package for the Gaussian polar sampler: word types and fixed constants.
`default_nettype none
package gps_pkg;

    // Input word: two uniforms, mean and sigma
    typedef struct packed {
        logic        [23:0] uniform_a;
        logic        [23:0] uniform_b;
        logic signed [31:0] mean;
        logic        [31:0] sigma;
    } in_t;

    // Output word: scaled sample and clamp flag
    typedef struct packed {
        logic signed [31:0] sample;
        logic               saturated;
    } out_t;

    // ln(2) in Q0.28
    localparam logic [31:0] LN2_Q28 = 32'd186065279;

    // Normal value width, signed Q4.20
    localparam int NORMAL_BITS = 24;

endpackage
`default_nettype wire

[sv/gaussian_polar_sampler_top.sv]
// Gaussian polar sampler: sequencer around one shared 32x32 multiplier.
// With a spare held, an accepted word passes ST_SCALE and ST_FIN to the output register.
// For a new pair: ST_SQA, ST_SQB, ST_CHK, ST_NORM, ST_LOG, ST_LNLO, ST_LNHI, then ST_DIV,
// ST_XLO, ST_XHI and ST_SQRT for each normal, then ST_SCALE and ST_FIN, plus any output stall;
// a rejected pair frees the block after ST_SQA, ST_SQB and ST_CHK.
// One word at a time; the log squarings, the divider and the square root dominate.
// Reset (rst_n low, asynchronous) clears the sequencer, the held spare and the output valid.
`default_nettype none
module gaussian_polar_sampler_top #(
    parameter int UNIFORM_BITS = 24
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire gps_pkg::in_t in_data,
    output logic              out_valid,
    input  wire logic         out_ready,
    output gps_pkg::out_t     out_data
);
    import gps_pkg::*;

    localparam int F   = UNIFORM_BITS;
    localparam int SHR = (2 * F >= 32) ? (2 * F - 32) : 0;
    localparam int SHL = (2 * F < 32) ? (32 - 2 * F) : 0;

    typedef enum logic [13:0] {
        ST_IDLE  = 14'b00000000000001,
        ST_SQA   = 14'b00000000000010,
        ST_SQB   = 14'b00000000000100,
        ST_CHK   = 14'b00000000001000,
        ST_NORM  = 14'b00000000010000,
        ST_LOG   = 14'b00000000100000,
        ST_LNLO  = 14'b00000001000000,
        ST_LNHI  = 14'b00000010000000,
        ST_DIV   = 14'b00000100000000,
        ST_XLO   = 14'b00001000000000,
        ST_XHI   = 14'b00010000000000,
        ST_SQRT  = 14'b00100000000000,
        ST_SCALE = 14'b01000000000000,
        ST_FIN   = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    // Control registers
    logic       spare_valid_reg, spare_valid_next;
    logic       part_reg, part_next;
    logic [5:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;

    // Payload registers
    logic [NORMAL_BITS-1:0] spare_reg, spare_next;
    logic [NORMAL_BITS-1:0] xbits_reg, xbits_next;
    logic signed [31:0]     mean_reg, mean_next;
    logic [31:0]            sigma_reg, sigma_next;
    logic [F-1:0]           m1_reg, m1_next, m2_reg, m2_next;
    logic                   n1_reg, n1_next, n2_reg, n2_next;
    logic                   z1_reg, z1_next, z2_reg, z2_next;
    logic [2*F-1:0]         asq_reg, asq_next, bsq_reg, bsq_next;
    logic [31:0]            a32_reg, a32_next, b32_reg, b32_next, s32_reg, s32_next;
    logic [31:0]            z_reg, z_next;
    logic [5:0]             k_reg, k_next;
    logic [29:0]            frac_reg, frac_next;
    logic [35:0]            n_reg, n_next;
    logic [63:0]            acc_reg, acc_next;
    logic [35:0]            twol_reg, twol_next;
    logic [32:0]            rem_reg, rem_next;
    logic [32:0]            quo_reg, quo_next;
    logic [47:0]            v_reg, v_next;
    logic [47:0]            res_reg, res_next;
    logic [47:0]            bit_reg, bit_next;
    logic [55:0]            prod_reg, prod_next;
    out_t                   out_reg, out_next;

    // Shared multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;

    // Helpers
    logic [F-1:0]   ua, ub;
    logic [F:0]     twa, twb, full;
    logic [F:0]     ma, mb;
    logic [2*F:0]   s_sum;
    logic [63:0]    asq64, bsq64;
    logic [31:0]    a32_c, b32_c;
    logic [32:0]    s32_c;
    logic [31:0]    lg_t;
    logic           div_ge;
    logic [32:0]    div_r;
    logic [47:0]    sq_sum;
    logic           x_neg;
    logic [23:0]    x_mag;
    logic [56:0]    q_round;
    logic [36:0]    q_val;
    logic signed [37:0] scaled, sum;
    out_t           fin_word;

    // Select shared multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_SQA:
            begin
                mul_a = 32'(m1_reg);
                mul_b = 32'(m1_reg);
            end
            ST_SQB:
            begin
                mul_a = 32'(m2_reg);
                mul_b = 32'(m2_reg);
            end
            ST_LOG:
            begin
                mul_a = z_reg;
                mul_b = z_reg;
            end
            ST_LNLO:
            begin
                mul_a = n_reg[31:0];
                mul_b = LN2_Q28;
            end
            ST_LNHI:
            begin
                mul_a = 32'(n_reg[35:32]);
                mul_b = LN2_Q28;
            end
            ST_XLO:
            begin
                mul_a = 32'(quo_reg[32:8]);
                mul_b = twol_reg[31:0];
            end
            ST_XHI:
            begin
                mul_a = 32'(quo_reg[32:8]);
                mul_b = 32'(twol_reg[35:32]);
            end
            ST_SCALE:
            begin
                mul_a = 32'(x_mag);
                mul_b = sigma_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = 64'(mul_a) * 64'(mul_b);

    // Map uniforms to |V| and sign
    assign ua   = F'(in_data.uniform_a);
    assign ub   = F'(in_data.uniform_b);
    assign twa  = {ua, 1'b0};
    assign twb  = {ub, 1'b0};
    assign full = (F+1)'(1) << F;
    assign ma   = ua[F-1] ? (twa - full) : (full - twa);
    assign mb   = ub[F-1] ? (twb - full) : (full - twb);

    // Radius and Q0.32 squares
    assign s_sum = (2*F+1)'(asq_reg) + (2*F+1)'(bsq_reg);
    assign asq64 = 64'(asq_reg);
    assign bsq64 = 64'(bsq_reg);
    assign a32_c = 32'((asq64 >> SHR) << SHL);
    assign b32_c = 32'((bsq64 >> SHR) << SHL);
    assign s32_c = 33'(a32_c) + 33'(b32_c);

    // Log squaring step
    assign lg_t = mul_p[61:30];

    // Divider step
    assign div_ge = (rem_reg >= {1'b0, s32_reg});
    assign div_r  = div_ge ? (rem_reg - {1'b0, s32_reg}) : rem_reg;

    // Square root step
    assign sq_sum = res_reg + bit_reg;

    // Scale, round and clamp
    assign x_neg   = xbits_reg[NORMAL_BITS-1];
    assign x_mag   = x_neg ? 24'(24'd0 - xbits_reg) : xbits_reg;
    assign q_round = x_neg ? (57'(prod_reg) + 57'((1 << 20) - 1)) : 57'(prod_reg);
    assign q_val   = q_round[56:20];
    assign scaled  = x_neg ? -$signed({1'b0, q_val}) : $signed({1'b0, q_val});
    assign sum     = $signed({{6{mean_reg[31]}}, mean_reg}) + scaled;

    always_comb
    begin
        fin_word.saturated = 1'b0;
        fin_word.sample    = 32'(sum);
        if (sum > 38'sd2147483647)
        begin
            fin_word.sample    = 32'h7FFFFFFF;
            fin_word.saturated = 1'b1;
        end
        else if (sum < -38'sd2147483648)
        begin
            fin_word.sample    = 32'h80000000;
            fin_word.saturated = 1'b1;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        spare_valid_next = spare_valid_reg;
        part_next        = part_reg;
        cnt_next         = cnt_reg;
        out_valid_next   = out_valid_reg;
        spare_next       = spare_reg;
        xbits_next       = xbits_reg;
        mean_next        = mean_reg;
        sigma_next       = sigma_reg;
        m1_next          = m1_reg;
        m2_next          = m2_reg;
        n1_next          = n1_reg;
        n2_next          = n2_reg;
        z1_next          = z1_reg;
        z2_next          = z2_reg;
        asq_next         = asq_reg;
        bsq_next         = bsq_reg;
        a32_next         = a32_reg;
        b32_next         = b32_reg;
        s32_next         = s32_reg;
        z_next           = z_reg;
        k_next           = k_reg;
        frac_next        = frac_reg;
        n_next           = n_reg;
        acc_next         = acc_reg;
        twol_next        = twol_reg;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        v_next           = v_reg;
        res_next         = res_reg;
        bit_next         = bit_reg;
        prod_next        = prod_reg;
        out_next         = out_reg;

        // Drop the output word once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    mean_next  = in_data.mean;
                    sigma_next = in_data.sigma;
                    if (spare_valid_reg)
                    begin
                        xbits_next       = spare_reg;
                        spare_valid_next = 1'b0;
                        state_next       = ST_SCALE;
                    end
                    else
                    begin
                        m1_next    = ma[F-1:0];
                        m2_next    = mb[F-1:0];
                        n1_next    = ~ua[F-1];
                        n2_next    = ~ub[F-1];
                        z1_next    = (ua == '0);
                        z2_next    = (ub == '0);
                        state_next = ST_SQA;
                    end
                end
            end
            ST_SQA:
            begin
                asq_next   = mul_p[2*F-1:0];
                state_next = ST_SQB;
            end
            ST_SQB:
            begin
                bsq_next   = mul_p[2*F-1:0];
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                a32_next = a32_c;
                b32_next = b32_c;
                s32_next = s32_c[31:0];
                z_next   = s32_c[31:0];
                cnt_next = '0;
                // Reject points outside the open disc or at the center
                if (z1_reg || z2_reg || s_sum[2*F] || (s_sum == '0) ||
                    (s32_c == '0) || s32_c[32])
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                // Bring the leading one to bit 30
                if (z_reg[31])
                begin
                    z_next     = z_reg >> 1;
                    k_next     = 6'd1;
                    cnt_next   = '0;
                    state_next = ST_LOG;
                end
                else if (z_reg[30])
                begin
                    k_next     = cnt_reg + 6'd2;
                    cnt_next   = '0;
                    state_next = ST_LOG;
                end
                else
                begin
                    z_next   = z_reg << 1;
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            ST_LOG:
            begin
                // One fraction bit of log2 per squaring
                if (lg_t[31])
                begin
                    z_next    = {1'b0, lg_t[31:1]};
                    frac_next = {frac_reg[28:0], 1'b1};
                end
                else
                begin
                    z_next    = {1'b0, lg_t[30:0]};
                    frac_next = {frac_reg[28:0], 1'b0};
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd29)
                begin
                    // Form N = (32 - p) * 2^30 - frac with the last fraction bit
                    n_next     = {k_reg, 30'd0} - 36'({frac_reg[28:0], lg_t[31]});
                    state_next = ST_LNLO;
                end
            end
            ST_LNLO:
            begin
                acc_next   = mul_p;
                state_next = ST_LNHI;
            end
            ST_LNHI:
            begin
                twol_next  = 36'(((acc_reg + {mul_p[31:0], 32'd0}) >> 28) << 1);
                rem_next   = {1'b0, a32_reg};
                quo_next   = '0;
                part_next  = 1'b0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                // One quotient bit per cycle
                quo_next = {quo_reg[31:0], div_ge};
                rem_next = {div_r[31:0], 1'b0};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd32)
                begin
                    state_next = ST_XLO;
                end
            end
            ST_XLO:
            begin
                acc_next   = mul_p;
                state_next = ST_XHI;
            end
            ST_XHI:
            begin
                v_next     = 48'((acc_reg + {mul_p[31:0], 32'd0}) >> 14);
                res_next   = '0;
                bit_next   = 48'd1 << 46;
                cnt_next   = '0;
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                // Two radicand bits per cycle
                if (v_reg >= sq_sum)
                begin
                    v_next   = v_reg - sq_sum;
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd23)
                begin
                    if (!part_reg)
                    begin
                        xbits_next = (n1_reg && res_next[23:0] != '0) ?
                                     24'(24'd0 - res_next[23:0]) : res_next[23:0];
                        part_next  = 1'b1;
                        rem_next   = {1'b0, b32_reg};
                        quo_next   = '0;
                        cnt_next   = '0;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        spare_next       = n2_reg ? 24'(24'd0 - res_next[23:0]) :
                                           res_next[23:0];
                        spare_valid_next = 1'b1;
                        state_next       = ST_SCALE;
                    end
                end
            end
            ST_SCALE:
            begin
                prod_next  = mul_p[55:0];
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_next       = fin_word;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            spare_valid_reg <= 1'b0;
            spare_reg       <= '0;
            part_reg        <= 1'b0;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            spare_valid_reg <= spare_valid_next;
            spare_reg       <= spare_next;
            part_reg        <= part_next;
            cnt_reg         <= cnt_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        xbits_reg <= xbits_next;
        mean_reg  <= mean_next;
        sigma_reg <= sigma_next;
        m1_reg    <= m1_next;
        m2_reg    <= m2_next;
        n1_reg    <= n1_next;
        n2_reg    <= n2_next;
        z1_reg    <= z1_next;
        z2_reg    <= z2_next;
        asq_reg   <= asq_next;
        bsq_reg   <= bsq_next;
        a32_reg   <= a32_next;
        b32_reg   <= b32_next;
        s32_reg   <= s32_next;
        z_reg     <= z_next;
        k_reg     <= k_next;
        frac_reg  <= frac_next;
        n_reg     <= n_next;
        acc_reg   <= acc_next;
        twol_reg  <= twol_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        v_reg     <= v_next;
        res_reg   <= res_next;
        bit_reg   <= bit_next;
        prod_reg  <= prod_next;
        out_reg   <= out_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // The divider remainder stays below twice the divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < {s32_reg, 1'b0}))
        else $error("divider remainder out of range");

    // A spare is only set at the end of the second root
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(spare_valid_reg) |-> $past(state_reg == ST_SQRT && part_reg))
        else $error("spare set outside second root");

    // A held spare goes straight to scaling
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && spare_valid_reg) |=> (state_reg == ST_SCALE))
        else $error("held spare not used");

    // A result is loaded only from the final state
    assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(out_valid_reg)) |-> $past(state_reg == ST_FIN))
        else $error("output loaded outside final state");

endmodule
`default_nettype wire
